### rtl/core/lrufr_pkg.sv
// shared types and constants for the lru frame replacement unit
package lrufr_pkg;

    // fixed field widths
    localparam int FIDX_W    = 4;
    localparam int CFG_W     = 5;
    localparam int OUTCOME_W = 2;

    // frames taking part in the scan after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // transaction kind carried on the input tuser
    localparam logic MODE_ACCESS = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // result kind carried on the output tuser
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2,
        OUT_READ  = 2'd3
    } outcome_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;     // capture per-frame compare flags
        logic upd_en;     // apply the page access
        logic any_found;  // some scanned frame is empty or holds the page
        logic is_fill;    // the chosen frame was empty
        logic dirty;      // access writes the page
    } cell_ctrl_t;

endpackage

### rtl/core/lrufr_cell.sv
// one page frame of the table: state, compare flags and update rules
module lrufr_cell #(
    parameter int IDX        = 0,
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 32,
    parameter int RANK_W     = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lrufr_pkg::cell_ctrl_t    ctrl,
    input  logic [PAGE_BITS-1:0]     page,
    input  logic [MAX_FRAMES-1:0]    in_scan_all,
    input  logic [RANK_W-1:0]        rank_all [MAX_FRAMES],
    input  logic [RANK_W-1:0]        chosen_rank,
    input  logic                     found_in,
    output logic                     found_out,
    output logic                     sel,
    output logic                     hit,
    output logic [RANK_W-1:0]        rank,
    output logic                     rpt_valid,
    output logic [PAGE_BITS-1:0]     rpt_page,
    output logic [COUNT_BITS-1:0]    rpt_faults,
    output logic [COUNT_BITS-1:0]    rpt_wb
);

    localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_FRAMES - 1);

    logic                  valid_reg, valid_next;
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic [RANK_W-1:0]     rank_reg, rank_next;
    logic [COUNT_BITS-1:0] faults_reg, faults_next;
    logic [COUNT_BITS-1:0] wb_reg, wb_next;
    logic                  qual_reg, hit_reg, oldest_reg;
    logic                  in_scan, same_page, oldest_c, passed;

    assign in_scan   = in_scan_all[IDX];
    assign same_page = valid_reg && (page_reg == page);

    // oldest scanned frame, lowest index wins a tie
    always_comb
    begin
        oldest_c = in_scan;
        for (int j = 0; j < MAX_FRAMES; j++)
        begin
            if (in_scan_all[j] && j < IDX && !(rank_all[j] < rank_reg))
                oldest_c = 1'b0;
            if (in_scan_all[j] && j > IDX && rank_all[j] > rank_reg)
                oldest_c = 1'b0;
        end
    end

    assign found_out = found_in | qual_reg;
    assign sel       = (qual_reg & ~found_in) | (~ctrl.any_found & oldest_reg);
    assign passed    = in_scan & ~found_in & ~qual_reg;
    assign hit       = hit_reg;
    assign rank      = rank_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        page_next   = page_reg;
        rank_next   = rank_reg;
        faults_next = faults_reg;
        wb_next     = wb_reg;
        if (ctrl.upd_en)
        begin
            if (passed && faults_reg != '1)
                faults_next = faults_reg + 1'b1;
            if (sel)
            begin
                valid_next = 1'b1;
                page_next  = page;
                rank_next  = '0;
                if ((!ctrl.any_found || ctrl.is_fill || ctrl.dirty) && wb_reg != '1)
                    wb_next = wb_reg + 1'b1;
            end
            else if (valid_reg)
            begin
                if (ctrl.is_fill ? (rank_reg < RANK_TOP) : (rank_reg < chosen_rank))
                    rank_next = rank_reg + 1'b1;
            end
        end
    end

    assign rpt_valid  = valid_next;
    assign rpt_page   = valid_next ? page_next : '0;
    assign rpt_faults = faults_next;
    assign rpt_wb     = wb_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            rank_reg   <= '0;
            faults_reg <= '0;
            wb_reg     <= '0;
            qual_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            oldest_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            rank_reg   <= rank_next;
            faults_reg <= faults_next;
            wb_reg     <= wb_next;
            if (ctrl.cmp_en)
            begin
                qual_reg   <= in_scan & (~valid_reg | same_page);
                hit_reg    <= in_scan & same_page;
                oldest_reg <= oldest_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

endmodule

### rtl/core/lru_frame_replacement_unit.sv
// top level: lru page-frame table built as a row of frame cells
//
// Fully associative table of MAX_FRAMES page frames with least-recently-used
// replacement. A page access (tuser 0) scans frames 0 .. frames_in_use-1 in
// index order and takes the first empty frame or the frame holding the page;
// failing both it evicts the scanned frame with the oldest recency rank
// (lowest index on a tie). A statistics read (tuser 1) reports one frame and
// changes nothing. Every transaction yields exactly one result. Each
// transaction passes a compare state, in which every cell compares its page
// and works out whether it is the oldest, then an update state, in which the
// found flag ripples along the row, the chosen frame is picked and all cells
// update; a new transaction is taken in that update state. Results sit in an
// output register, so a new transaction is taken while the previous result
// waits; only the update state waits for that register to drain.
// frames_in_use is written through cfg_we/cfg_wdata; the user must do so only
// while the unit is idle, which the unit does not enforce. 0 acts as 1 and
// values above MAX_FRAMES act as MAX_FRAMES. Counters saturate at all ones.
module lru_frame_replacement_unit #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    // configuration: frames_in_use
    input  logic                          cfg_we,
    input  logic [lrufr_pkg::CFG_W-1:0]   cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // page_number, dirty, frame_select (from bit 0 up), zero padded
    input  logic [((PAGE_BITS+1+lrufr_pkg::FIDX_W+7)/8)*8-1:0] s_tdata,
    // mode
    input  logic                          s_tuser,
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // frame_index, frame_valid, frame_page, fault_count, writeback_count
    // (from bit 0 up), zero padded
    output logic [((lrufr_pkg::FIDX_W+1+PAGE_BITS+2*COUNT_BITS+7)/8)*8-1:0] m_tdata,
    // outcome
    output logic [lrufr_pkg::OUTCOME_W-1:0] m_tuser
);

    localparam int OUT_W  = ((lrufr_pkg::FIDX_W + 1 + PAGE_BITS + 2*COUNT_BITS + 7)/8)*8;
    localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NCNT_W = $clog2(MAX_FRAMES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    state_t state_reg;

    // configuration register
    logic [lrufr_pkg::CFG_W-1:0] frames_in_use_reg;

    // transaction held while it is worked on
    logic                           mode_reg;
    logic [PAGE_BITS-1:0]           page_reg;
    logic                           dirty_reg;
    logic [lrufr_pkg::FIDX_W-1:0]   select_reg;

    // result register
    logic                           out_valid_reg;
    logic [lrufr_pkg::FIDX_W-1:0]   out_idx_reg;
    lrufr_pkg::outcome_t            out_kind_reg;
    logic                           out_fvalid_reg;
    logic [PAGE_BITS-1:0]           out_page_reg;
    logic [COUNT_BITS-1:0]          out_faults_reg;
    logic [COUNT_BITS-1:0]          out_wb_reg;

    // cell row
    lrufr_pkg::cell_ctrl_t          ctrl;
    logic [MAX_FRAMES:0]            found_chain;
    logic [MAX_FRAMES-1:0]          sel_vec, hit_vec, in_scan, rpt_hot;
    logic [RANK_W-1:0]              rank_all [MAX_FRAMES];
    logic                           rpt_valid_all [MAX_FRAMES];
    logic [PAGE_BITS-1:0]           rpt_page_all [MAX_FRAMES];
    logic [COUNT_BITS-1:0]          rpt_faults_all [MAX_FRAMES];
    logic [COUNT_BITS-1:0]          rpt_wb_all [MAX_FRAMES];

    logic [NCNT_W-1:0]              n_eff;
    logic                           accept, out_free, upd_go, chosen_hit;
    logic [RANK_W-1:0]              chosen_rank;
    logic [lrufr_pkg::FIDX_W-1:0]   chosen_idx, rpt_idx;
    lrufr_pkg::outcome_t            kind;
    logic                           rpt_valid;
    logic [PAGE_BITS-1:0]           rpt_page;
    logic [COUNT_BITS-1:0]          rpt_faults, rpt_wb;

    // handshake: take a transaction when idle or while finishing the last one
    assign out_free = ~out_valid_reg | m_tready;
    assign upd_go   = (state_reg == ST_UPD) && out_free;
    assign s_tready = (state_reg == ST_IDLE) || upd_go;
    assign accept   = s_tvalid & s_tready;

    // effective number of scanned frames
    always_comb
    begin
        if (frames_in_use_reg == '0)
            n_eff = NCNT_W'(1);
        else if (int'(frames_in_use_reg) > MAX_FRAMES)
            n_eff = NCNT_W'(MAX_FRAMES);
        else
            n_eff = NCNT_W'(frames_in_use_reg);
    end

    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
            in_scan[i] = (i < int'(n_eff));
    end

    // the found flag runs from frame 0 upward through the row
    assign found_chain[0] = 1'b0;

    // chosen frame: one-hot from the row, folded into index and rank
    always_comb
    begin
        chosen_idx  = '0;
        chosen_rank = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (sel_vec[i])
            begin
                chosen_idx  = chosen_idx | lrufr_pkg::FIDX_W'(i);
                chosen_rank = chosen_rank | rank_all[i];
            end
        end
    end

    assign chosen_hit = |(sel_vec & hit_vec);

    always_comb
    begin
        ctrl.cmp_en    = (state_reg == ST_CMP);
        ctrl.upd_en    = upd_go && (mode_reg == lrufr_pkg::MODE_ACCESS);
        ctrl.any_found = found_chain[MAX_FRAMES];
        ctrl.is_fill   = found_chain[MAX_FRAMES] & ~chosen_hit;
        ctrl.dirty     = dirty_reg;
    end

    // outcome of the transaction
    always_comb
    begin
        if (mode_reg == lrufr_pkg::MODE_READ)
            kind = lrufr_pkg::OUT_READ;
        else if (!found_chain[MAX_FRAMES])
            kind = lrufr_pkg::OUT_EVICT;
        else if (chosen_hit)
            kind = lrufr_pkg::OUT_HIT;
        else
            kind = lrufr_pkg::OUT_FILL;
    end

    // frame to report: the chosen one, or the selected one for a read;
    // a selection beyond the table matches no cell and reports zeros
    assign rpt_idx = (mode_reg == lrufr_pkg::MODE_READ) ? select_reg : chosen_idx;

    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
            rpt_hot[i] = (mode_reg == lrufr_pkg::MODE_READ) ?
                         (i == int'(select_reg)) : sel_vec[i];
    end

    always_comb
    begin
        rpt_valid  = 1'b0;
        rpt_page   = '0;
        rpt_faults = '0;
        rpt_wb     = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (rpt_hot[i])
            begin
                rpt_valid  = rpt_valid | rpt_valid_all[i];
                rpt_page   = rpt_page | rpt_page_all[i];
                rpt_faults = rpt_faults | rpt_faults_all[i];
                rpt_wb     = rpt_wb | rpt_wb_all[i];
            end
        end
    end

    // row of frame cells
    for (genvar g = 0; g < MAX_FRAMES; g++)
    begin : g_cell
        lrufr_cell #(
            .IDX        (g),
            .MAX_FRAMES (MAX_FRAMES),
            .PAGE_BITS  (PAGE_BITS),
            .COUNT_BITS (COUNT_BITS),
            .RANK_W     (RANK_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .page        (page_reg),
            .in_scan_all (in_scan),
            .rank_all    (rank_all),
            .chosen_rank (chosen_rank),
            .found_in    (found_chain[g]),
            .found_out   (found_chain[g+1]),
            .sel         (sel_vec[g]),
            .hit         (hit_vec[g]),
            .rank        (rank_all[g]),
            .rpt_valid   (rpt_valid_all[g]),
            .rpt_page    (rpt_page_all[g]),
            .rpt_faults  (rpt_faults_all[g]),
            .rpt_wb      (rpt_wb_all[g])
        );
    end

    // sequencer, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            frames_in_use_reg <= lrufr_pkg::CFG_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                frames_in_use_reg <= cfg_wdata;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                        state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    if (upd_go)
                        state_reg <= accept ? ST_CMP : ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (upd_go)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= s_tuser;
            page_reg   <= s_tdata[PAGE_BITS-1:0];
            dirty_reg  <= s_tdata[PAGE_BITS];
            select_reg <= s_tdata[PAGE_BITS+lrufr_pkg::FIDX_W:PAGE_BITS+1];
        end
        if (upd_go)
        begin
            out_idx_reg    <= rpt_idx;
            out_kind_reg   <= kind;
            out_fvalid_reg <= rpt_valid;
            out_page_reg   <= rpt_page;
            out_faults_reg <= rpt_faults;
            out_wb_reg     <= rpt_wb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = OUT_W'({out_wb_reg, out_faults_reg, out_page_reg,
                              out_fvalid_reg, out_idx_reg});

endmodule
